FILE: rtl/ssca_pkg.sv
// Package for the slab size-class allocator: widths, codes, sequencer states.
// No dependencies.
package ssca_pkg;
  localparam int ClassCount = 6;
  localparam int ObjectsPerSlab = 64;
  localparam int PoolMaxBytes = 65536;
  localparam int GrainShift = 4;
  localparam int LinkDepth = PoolMaxBytes >> GrainShift;
  localparam int GW = $clog2(LinkDepth);        // granule index width
  localparam int HW = GW + 1;                   // head/link encoding width
  localparam int CW = 3;
  localparam int OW = $clog2(ObjectsPerSlab + 1);
  localparam logic [CW-1:0] ClassNone = CW'(ClassCount);

  typedef enum logic [2:0] {
    ST_SLAB = 3'd0, ST_BUMP = 3'd1, ST_FAIL = 3'd2, ST_FREED = 3'd3, ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CARVE, S_POP_RD, S_POP_WAIT, S_DONE
  } state_t;

  localparam logic [0:0] RegPoolBytes = 1'b0;
  localparam logic [0:0] RegPoolPresent = 1'b1;

  function automatic logic [16:0] class_size(input logic [CW-1:0] c);
    class_size = 17'(32) << c;
  endfunction
endpackage

FILE: rtl/ssca_if.sv
// Valid/ready channel interfaces for the allocator's request and result items.
// No dependencies.
interface ssca_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [16:0] req_size;
  logic [16:0] free_offset;
  modport source (output valid, func, req_size, free_offset, input ready);
  modport sink (input valid, func, req_size, free_offset, output ready);
endinterface

interface ssca_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] alloc_offset;
  logic [2:0]  class_used;
  modport source (output valid, status, alloc_offset, class_used, input ready);
  modport sink (input valid, status, alloc_offset, class_used, output ready);
endinterface

FILE: rtl/ssca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ssca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/slab_size_class_allocator_unit.sv
// Slab size-class allocator. One request item in, one result item out, every item.
// An allocate that hits an empty class carves a slab: one link-memory write per
// object, then a read of the link memory, its wait and the result. A pop from a
// non-empty list takes the registered read of the link memory and its wait before
// the result; every other request goes straight to the result. The block takes one
// item at a time; in_ready is low from acceptance until the result item is taken.
// Configuration: register 0 (pool_bytes) at address 0, register 1 (pool_present) at
// address 4. Link memory needs no clearing pass: list operations never read a word
// that was not written.
module slab_size_class_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  ssca_req_if.sink    in_ch,
  ssca_rsp_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ssca_pkg::*;

  state_t state_r, state_nxt;
  logic [16:0] pool_bytes_r;
  logic        pool_present_r;
  logic [16:0] pool_used_r, pool_used_nxt;
  logic [HW-1:0] head_r [ClassCount];
  logic [ClassCount-1:0] has_slabs_r;
  logic [CW-1:0] cls_r, cls_nxt;
  logic [16:0] base_r, base_nxt;          // carve cursor
  logic [OW-1:0] cnt_r, cnt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [15:0] off_r, off_nxt;
  logic [CW-1:0] cu_r, cu_nxt;

  // memory port
  logic          we;
  logic [GW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata;

  ssca_ram #(.Width(HW), .Depth(LinkDepth)) u_link (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // configuration
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr[2])
      RegPoolBytes:   cfg_prdata = {15'd0, pool_bytes_r};
      RegPoolPresent: cfg_prdata = {31'd0, pool_present_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // decode of the accepted item
  logic [16:0] limit;
  logic [CW-1:0] a_cls, f_cls;
  logic a_fit, f_hit;
  logic [17:0] bump_end, slab_end;
  logic [17:0] aligned;                   // one bit wider: rounding may pass 17 bits
  logic [16:0] span;
  assign limit = (pool_bytes_r > 17'(PoolMaxBytes)) ? 17'(PoolMaxBytes) : pool_bytes_r;
  always_comb begin
    a_cls = ClassNone; a_fit = 1'b0;
    f_cls = ClassNone; f_hit = 1'b0;
    for (int c = ClassCount - 1; c >= 0; c--) begin
      if (in_ch.req_size <= class_size(CW'(c))) begin
        a_cls = CW'(c); a_fit = 1'b1;
      end
      if (((in_ch.free_offset & (class_size(CW'(c)) - 17'd1)) == 17'd0) && has_slabs_r[c]) begin
        f_cls = CW'(c); f_hit = 1'b1;
      end
    end
  end
  assign aligned = ({1'b0, in_ch.req_size} + 18'd15) & ~18'd15;
  assign bump_end = {1'b0, pool_used_r} + aligned;
  assign span = class_size(a_cls) * 17'(ObjectsPerSlab);
  assign slab_end = {1'b0, pool_used_r} + {1'b0, span};

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_DONE);
  assign out_ch.status = st_r;
  assign out_ch.alloc_offset = off_r;
  assign out_ch.class_used = cu_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        if (!in_ch.func && pool_present_r && in_ch.req_size != 0 && a_fit) begin
          if (head_r[a_cls] != '0) state_nxt = S_POP_RD;
          else if (slab_end <= {1'b0, limit}) state_nxt = S_CARVE;
          else state_nxt = S_DONE;
        end else state_nxt = S_DONE;
      end
      S_CARVE:    if (cnt_r == OW'(ObjectsPerSlab - 1)) state_nxt = S_POP_RD;
      S_POP_RD:   state_nxt = S_POP_WAIT;
      S_POP_WAIT: state_nxt = S_DONE;
      S_DONE:     if (out_ch.ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath
  logic [HW-1:0] cur_head;
  assign cur_head = head_r[cls_r];
  always_comb begin
    pool_used_nxt = pool_used_r;
    cls_nxt = cls_r; base_nxt = base_r; cnt_nxt = cnt_r;
    st_nxt = st_r; off_nxt = off_r; cu_nxt = cu_r;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = GW'(cur_head - HW'(1));
    case (state_r)
      S_IDLE: if (accept) begin
        st_nxt = ST_FAIL; off_nxt = '0; cu_nxt = ClassNone;
        cls_nxt = a_cls; cnt_nxt = '0; base_nxt = pool_used_r;
        if (!in_ch.func) begin
          if (pool_present_r && in_ch.req_size != 0) begin
            if (!a_fit) begin
              if (bump_end <= {1'b0, limit}) begin
                st_nxt = ST_BUMP; off_nxt = pool_used_r[15:0];
                pool_used_nxt = bump_end[16:0];
              end
            end else if (head_r[a_cls] == '0 && slab_end <= {1'b0, limit}) begin
              pool_used_nxt = slab_end[16:0];
            end
          end
        end else begin
          st_nxt = ST_IGNORED;
          if (pool_present_r && in_ch.free_offset < limit && f_hit) begin
            st_nxt = ST_FREED; cu_nxt = f_cls; cls_nxt = f_cls;
            we = 1'b1;
            waddr = in_ch.free_offset[GrainShift +: GW];
            wdata = head_r[f_cls];
          end
        end
      end
      S_CARVE: begin
        // push the next object: link to current head
        we = 1'b1; waddr = base_r[GrainShift +: GW]; wdata = cur_head;
        base_nxt = base_r + class_size(cls_r);
        cnt_nxt = cnt_r + OW'(1);
      end
      S_POP_WAIT: begin
        st_nxt = ST_SLAB; cu_nxt = cls_r;
        off_nxt = 16'(raddr) << GrainShift;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pool_bytes_r <= 17'(PoolMaxBytes);
      pool_present_r <= 1'b1;
      pool_used_r <= '0;
      has_slabs_r <= '0;
      for (int c = 0; c < ClassCount; c++) head_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      pool_used_r <= pool_used_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[2])
          RegPoolBytes:   pool_bytes_r <= cfg_pwdata[16:0];
          RegPoolPresent: pool_present_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (we) head_r[state_r == S_CARVE ? cls_r : cls_nxt] <= HW'(waddr) + HW'(1);
      if (state_r == S_CARVE) has_slabs_r[cls_r] <= 1'b1;
      if (state_r == S_POP_WAIT) head_r[cls_r] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt; base_r <= base_nxt; cnt_r <= cnt_nxt;
    st_r <= st_nxt; off_r <= off_nxt; cu_r <= cu_nxt;
  end
endmodule

FILE: rtl/ssca_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on ssca_pkg.
module ssca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] alloc_offset,
  input logic [2:0]  class_used
);
  import ssca_pkg::*;
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FAIL || status == ST_FREED || status == ST_IGNORED)
    |-> alloc_offset == 16'd0) else $error("offset on no grant");
  a_class_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_BUMP || status == ST_FAIL || status == ST_IGNORED)
    |-> class_used == ClassNone) else $error("class on no class");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
endmodule

bind slab_size_class_allocator_unit ssca_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
  .alloc_offset(out_ch.alloc_offset), .class_used(out_ch.class_used)
);

FILE: verif/slab_size_class_allocator_unit_tb.sv
// Self-checking bench for the slab size-class allocator: drives request items,
// predicts each result from a behavioural copy of the allocator, checks results.
// Depends on ssca_pkg, ssca_if and slab_size_class_allocator_unit.
module slab_size_class_allocator_unit_tb;
  import ssca_pkg::*;

  typedef struct packed {
    logic        func;
    logic [16:0] req_size;
    logic [16:0] free_offset;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] alloc_offset;
    logic [2:0]  class_used;
  } grant_t;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;
  localparam int   CycleLimit = 400000;

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  ssca_req_if in_ch ();
  ssca_rsp_if out_ch ();

  slab_size_class_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predictor state: a mirror of the allocator's bump pointer, lists and links.
  logic [16:0] mdl_pool_bytes;
  logic        mdl_pool_present;
  logic [16:0] mdl_pool_used;
  logic [HW-1:0] mdl_head [ClassCount];
  logic          mdl_owns [ClassCount];
  logic [HW-1:0] mdl_link [LinkDepth];

  req_item_t pending_reqs[$];
  grant_t    awaited_grants[$];
  int        fail_count;
  int        cycle_count;
  logic      idle_enable;
  logic      hold_sender;

  // Push an object offset onto one class list.
  function automatic void push_object(int c, logic [16:0] offset);
    int g;
    g = (offset >> GrainShift) % LinkDepth;
    mdl_link[g] = mdl_head[c];
    mdl_head[c] = HW'(g + 1);
  endfunction

  // Work out the result of one accepted request and advance the mirror.
  function automatic grant_t allocate_or_free(req_item_t r);
    grant_t      res;
    int          c, g;
    logic [16:0] limit;
    int          aligned, span, base;
    res = '{ST_FAIL, 16'd0, ClassNone};
    limit = (mdl_pool_bytes > 17'(PoolMaxBytes)) ? 17'(PoolMaxBytes) : mdl_pool_bytes;
    if (r.func == FuncAlloc) begin
      if (!mdl_pool_present || r.req_size == 0) return res;
      for (c = 0; c < ClassCount; c++)
        if (r.req_size <= (32 << c)) break;
      if (c == ClassCount) begin
        aligned = (r.req_size + 15) & ~15;
        if (mdl_pool_used + aligned > limit) return res;
        res = '{ST_BUMP, mdl_pool_used[15:0], ClassNone};
        mdl_pool_used = mdl_pool_used + 17'(aligned);
        return res;
      end
      if (mdl_head[c] == 0) begin
        span = (32 << c) * ObjectsPerSlab;
        base = mdl_pool_used;
        if (base + span > limit) return res;
        mdl_pool_used = 17'(base + span);
        for (int i = 0; i < ObjectsPerSlab; i++) push_object(c, 17'(base + i * (32 << c)));
        mdl_owns[c] = 1'b1;
      end
      g = (mdl_head[c] - 1) % LinkDepth;
      mdl_head[c] = mdl_link[g];
      return '{ST_SLAB, 16'(g << GrainShift), 3'(c)};
    end
    res = '{ST_IGNORED, 16'd0, ClassNone};
    if (!mdl_pool_present || r.free_offset >= limit) return res;
    for (c = 0; c < ClassCount; c++) begin
      if ((r.free_offset & ((32 << c) - 1)) == 0 && mdl_owns[c]) begin
        push_object(c, r.free_offset);
        return '{ST_FREED, 16'd0, 3'(c)};
      end
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: take pending items in order, idle at random while idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        awaited_grants.push_back(allocate_or_free(pending_reqs.pop_front()));
      end
      if (pending_reqs.size() > 0 && !hold_sender &&
          !(idle_enable && $urandom_range(99) < 24)) begin
        in_ch.valid       <= 1'b1;
        in_ch.func        <= pending_reqs[0].func;
        in_ch.req_size    <= pending_reqs[0].req_size;
        in_ch.free_offset <= pending_reqs[0].free_offset;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result taken with the oldest prediction.
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_grants.size() == 0) begin
          $error("unexpected result item, status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = awaited_grants.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.alloc_offset !== want.alloc_offset) begin
            $error("alloc_offset: expected %0h, got %0h", want.alloc_offset,
                   out_ch.alloc_offset);
            fail_count++;
          end
          if (out_ch.class_used !== want.class_used) begin
            $error("class_used: expected %0d, got %0d", want.class_used, out_ch.class_used);
            fail_count++;
          end
        end
      end
      out_ch.ready <= !(idle_enable && $urandom_range(99) < 24);
    end
  end

  // Cycle guard: end the run on a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == RegPoolBytes) mdl_pool_bytes = value[16:0];
    else mdl_pool_present = value[0];
  endtask

  // Wait until every request is accepted and every result taken, then settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || awaited_grants.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic add_req(logic func, logic [16:0] size, logic [16:0] offset);
    pending_reqs.push_back('{func, size, offset});
  endtask

  // Mostly sizes that hit the classes, some bump blocks and odd sizes.
  function automatic logic [16:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return 17'($urandom_range(1, 32 << $urandom_range(ClassCount - 1)));
    if (k < 85) return 17'($urandom_range(1025, 4096));
    if (k < 92) return 17'($urandom_range(0, 131071));
    return 17'(0);
  endfunction

  // Frees mostly hit class-aligned offsets below the bump pointer.
  function automatic logic [16:0] pick_offset();
    int k;
    k = $urandom_range(99);
    if (k < 75) return 17'((mdl_pool_used == 0 ? 0 : $urandom_range(mdl_pool_used - 1))
                           & ~((32 << $urandom_range(ClassCount - 1)) - 1));
    if (k < 90) return 17'($urandom_range(0, 65535));
    return 17'($urandom_range(0, 131071));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55) add_req(FuncAlloc, pick_size(), 17'($urandom));
      else add_req(FuncFree, 17'($urandom), pick_offset());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_enable = 1'b1;
    hold_sender = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.req_size = '0; in_ch.free_offset = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    mdl_pool_bytes = 17'(PoolMaxBytes);
    mdl_pool_present = 1'b1;
    mdl_pool_used = '0;
    for (int c = 0; c < ClassCount; c++) begin
      mdl_head[c] = '0;
      mdl_owns[c] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: free with no owner, zero size, classes 0, 1, 3, 4 and 5, bump, limits.
    write_reg(RegPoolBytes, 32'h1ffff);
    write_reg(RegPoolPresent, 32'd1);
    add_req(FuncFree, 17'd0, 17'd0);
    add_req(FuncAlloc, 17'd0, 17'd0);
    add_req(FuncAlloc, 17'd1, 17'd0);
    add_req(FuncAlloc, 17'd32, 17'd0);
    add_req(FuncAlloc, 17'd33, 17'd0);
    add_req(FuncAlloc, 17'd200, 17'd0);
    add_req(FuncAlloc, 17'd256, 17'd0);
    add_req(FuncAlloc, 17'd512, 17'd0);
    add_req(FuncAlloc, 17'd1024, 17'd0);
    add_req(FuncAlloc, 17'd1025, 17'd0);
    add_req(FuncFree, 17'd0, 17'd32);
    add_req(FuncFree, 17'd0, 17'd32);
    add_req(FuncFree, 17'd0, 17'd16);
    add_req(FuncFree, 17'd0, 17'h1ffff);
    add_req(FuncFree, 17'd0, 17'h0ffff);
    add_req(FuncAlloc, 17'h1ffff, 17'd0);
    add_req(FuncAlloc, 17'd20000, 17'd0);
    add_req(FuncAlloc, 17'd1024, 17'd0);
    drain();
    // No pool attached, then shrink below what is used.
    write_reg(RegPoolPresent, 32'd0);
    add_req(FuncAlloc, 17'd32, 17'd0);
    add_req(FuncFree, 17'd0, 17'd64);
    drain();
    write_reg(RegPoolPresent, 32'd1);
    write_reg(RegPoolBytes, 32'd0);
    add_req(FuncAlloc, 17'd32, 17'd0);
    add_req(FuncAlloc, 17'd2000, 17'd0);
    add_req(FuncFree, 17'd0, 17'd0);
    drain();

    // Random phases across pool settings; the middle one runs without idling.
    write_reg(RegPoolBytes, 32'd65536);
    random_phase(150);
    drain();
    idle_enable = 1'b0;
    write_reg(RegPoolBytes, 32'h1ffff);
    random_phase(120);
    drain();
    idle_enable = 1'b1;

    // Mid-stream, hold the sender until every result has come, then release.
    random_phase(10);
    repeat (30) @(posedge clk);
    hold_sender = 1'b1;
    while (in_ch.valid || awaited_grants.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    write_reg(RegPoolBytes, 32'd40000);
    random_phase(120);
    drain();

    if (fail_count == 0 && awaited_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
